// ===== rtl/core/dcsm_pkg.sv =====
`default_nettype none
package dcsm_pkg;

    localparam int CNT_W = 16;

    // configuration register indexes
    localparam logic CFG_TICKS_PER_SECOND  = 1'b0;
    localparam logic CFG_BLINK_HALF_PERIOD = 1'b1;

    localparam logic CMD_TICK = 1'b0;

    // pressed-key action codes
    localparam logic [3:0] KEY_ENTER = 4'd1;
    localparam logic [3:0] KEY_NEXT  = 4'd3;
    localparam logic [3:0] KEY_INC   = 4'd5;
    localparam logic [3:0] KEY_DEC   = 4'd6;
    localparam logic [3:0] KEY_APPLY = 4'd7;
    localparam logic [3:0] KEY_EXIT  = 4'd8;

    localparam logic [4:0] HOUR_MAX   = 5'd23;
    localparam logic [5:0] MINSEC_MAX = 6'd59;
    localparam logic [5:0] MINSEC_MOD = 6'd60;
    localparam logic [4:0] HOUR_MOD   = 5'd24;
    localparam logic [3:0] BLANK      = 4'd10;

    typedef enum logic [1:0] {
        FIELD_HOURS   = 2'd0,
        FIELD_MINUTES = 2'd1,
        FIELD_SECONDS = 2'd2
    } field_t;

    // what the display formatter needs after one item
    typedef struct packed {
        logic       set_mode;
        field_t     field;
        logic       blink_on;
        logic [4:0] hh;
        logic [5:0] mm;
        logic [5:0] ss;
        logic [4:0] set_hh;
        logic [5:0] set_mm;
        logic [5:0] set_ss;
    } view_t;

    // tens digit of a value below 64 by compares
    function automatic logic [3:0] tens_of(input logic [5:0] v);
        logic [3:0] t;
        if (v >= 6'd60)      t = 4'd6;
        else if (v >= 6'd50) t = 4'd5;
        else if (v >= 6'd40) t = 4'd4;
        else if (v >= 6'd30) t = 4'd3;
        else if (v >= 6'd20) t = 4'd2;
        else if (v >= 6'd10) t = 4'd1;
        else                 t = 4'd0;
        return t;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/dcsm_core.sv =====
`default_nettype none
module dcsm_core (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_we,
    input  wire logic                      cfg_idx,
    input  wire logic [dcsm_pkg::CNT_W-1:0] cfg_wdata,
    input  wire logic                      fire,
    input  wire logic                      cmd,
    input  wire logic [3:0]                key,
    output dcsm_pkg::view_t                view
);

    logic [dcsm_pkg::CNT_W-1:0] tps_reg, bhp_reg;
    logic [dcsm_pkg::CNT_W-1:0] sec_cnt_reg, sec_cnt_next, sec_inc;
    logic [dcsm_pkg::CNT_W-1:0] blk_cnt_reg, blk_cnt_next, blk_inc;
    logic [4:0] hh_reg, hh_next, shh_reg, shh_next;
    logic [5:0] mm_reg, mm_next, smm_reg, smm_next;
    logic [5:0] ss_reg, ss_next, sss_reg, sss_next;
    logic       mode_reg, mode_next, blink_reg, blink_next;
    dcsm_pkg::field_t field_reg, field_next;
    logic [3:0] prev_reg, prev_next, pressed;
    logic       sec_fire, blk_fire;
    logic [5:0] ss_inc, mm_inc;
    logic [4:0] hh_inc;

    assign sec_inc  = sec_cnt_reg + 1'b1;
    assign blk_inc  = blk_cnt_reg + 1'b1;
    assign sec_fire = (sec_inc >= tps_reg) || (sec_inc == '0);
    assign blk_fire = (blk_inc >= bhp_reg) || (blk_inc == '0);
    assign ss_inc   = ss_reg + 1'b1;
    assign mm_inc   = mm_reg + 1'b1;
    assign hh_inc   = hh_reg + 1'b1;
    assign pressed  = key & ~prev_reg;

    always_comb begin
        sec_cnt_next = sec_cnt_reg;
        blk_cnt_next = blk_cnt_reg;
        hh_next      = hh_reg;
        mm_next      = mm_reg;
        ss_next      = ss_reg;
        shh_next     = shh_reg;
        smm_next     = smm_reg;
        sss_next     = sss_reg;
        mode_next    = mode_reg;
        blink_next   = blink_reg;
        field_next   = field_reg;
        prev_next    = prev_reg;
        if (cmd == dcsm_pkg::CMD_TICK) begin
            sec_cnt_next = sec_fire ? '0 : sec_inc;
            if (sec_fire) begin
                if (ss_inc >= dcsm_pkg::MINSEC_MOD) begin
                    ss_next = '0;
                    if (mm_inc >= dcsm_pkg::MINSEC_MOD) begin
                        mm_next = '0;
                        hh_next = (hh_inc >= dcsm_pkg::HOUR_MOD) ? '0 : hh_inc;
                    end else begin
                        mm_next = mm_inc;
                    end
                end else begin
                    ss_next = ss_inc;
                end
            end
            blk_cnt_next = blk_fire ? '0 : blk_inc;
            if (blk_fire) blink_next = ~blink_reg;
        end else begin
            prev_next = key;
            unique case (pressed)
                dcsm_pkg::KEY_ENTER: begin
                    shh_next  = hh_reg;
                    smm_next  = mm_reg;
                    sss_next  = ss_reg;
                    mode_next = 1'b1;
                end
                dcsm_pkg::KEY_NEXT: begin
                    if (mode_reg) begin
                        unique case (field_reg)
                            dcsm_pkg::FIELD_HOURS:   field_next = dcsm_pkg::FIELD_MINUTES;
                            dcsm_pkg::FIELD_MINUTES: field_next = dcsm_pkg::FIELD_SECONDS;
                            default:                 field_next = dcsm_pkg::FIELD_HOURS;
                        endcase
                    end
                end
                dcsm_pkg::KEY_INC: begin
                    if (mode_reg) begin
                        unique case (field_reg)
                            dcsm_pkg::FIELD_HOURS:
                                shh_next = (shh_reg >= dcsm_pkg::HOUR_MAX) ? '0 : shh_reg + 1'b1;
                            dcsm_pkg::FIELD_MINUTES:
                                smm_next = (smm_reg >= dcsm_pkg::MINSEC_MAX) ? '0 : smm_reg + 1'b1;
                            dcsm_pkg::FIELD_SECONDS:
                                sss_next = (sss_reg >= dcsm_pkg::MINSEC_MAX) ? '0 : sss_reg + 1'b1;
                            default: ;
                        endcase
                    end
                end
                dcsm_pkg::KEY_DEC: begin
                    if (mode_reg) begin
                        unique case (field_reg)
                            dcsm_pkg::FIELD_HOURS:
                                shh_next = (shh_reg == '0) ? dcsm_pkg::HOUR_MAX : shh_reg - 1'b1;
                            dcsm_pkg::FIELD_MINUTES:
                                smm_next = (smm_reg == '0) ? dcsm_pkg::MINSEC_MAX : smm_reg - 1'b1;
                            dcsm_pkg::FIELD_SECONDS:
                                sss_next = (sss_reg == '0) ? dcsm_pkg::MINSEC_MAX : sss_reg - 1'b1;
                            default: ;
                        endcase
                    end
                end
                dcsm_pkg::KEY_APPLY: begin
                    // applies even outside set mode
                    hh_next   = shh_reg;
                    mm_next   = smm_reg;
                    ss_next   = sss_reg;
                    mode_next = 1'b0;
                end
                dcsm_pkg::KEY_EXIT: mode_next = 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg     <= 16'd1000;
            bhp_reg     <= 16'd500;
            sec_cnt_reg <= '0;
            blk_cnt_reg <= '0;
            hh_reg      <= dcsm_pkg::HOUR_MAX;
            mm_reg      <= dcsm_pkg::MINSEC_MAX;
            ss_reg      <= 6'd55;
            shh_reg     <= '0;
            smm_reg     <= '0;
            sss_reg     <= '0;
            mode_reg    <= 1'b0;
            blink_reg   <= 1'b0;
            field_reg   <= dcsm_pkg::FIELD_HOURS;
            prev_reg    <= '0;
        end else begin
            if (cfg_we) begin
                if (cfg_idx == dcsm_pkg::CFG_TICKS_PER_SECOND) tps_reg <= cfg_wdata;
                else                                           bhp_reg <= cfg_wdata;
            end
            if (fire) begin
                sec_cnt_reg <= sec_cnt_next;
                blk_cnt_reg <= blk_cnt_next;
                hh_reg      <= hh_next;
                mm_reg      <= mm_next;
                ss_reg      <= ss_next;
                shh_reg     <= shh_next;
                smm_reg     <= smm_next;
                sss_reg     <= sss_next;
                mode_reg    <= mode_next;
                blink_reg   <= blink_next;
                field_reg   <= field_next;
                prev_reg    <= prev_next;
            end
        end
    end

    // view reflects the state after this item
    always_comb begin
        view.set_mode = mode_next;
        view.field    = field_next;
        view.blink_on = blink_next;
        view.hh       = hh_next;
        view.mm       = mm_next;
        view.ss       = ss_next;
        view.set_hh   = shh_next;
        view.set_mm   = smm_next;
        view.set_ss   = sss_next;
    end

endmodule
`default_nettype wire

// ===== rtl/core/dcsm_display.sv =====
`default_nettype none
module dcsm_display (
    input  wire dcsm_pkg::view_t view,
    output logic [23:0]          digits
);

    logic [5:0] val [3];
    logic       blank [3];
    logic [3:0] tens [3];
    logic [3:0] ones [3];
    logic       dark;

    assign dark = view.set_mode && !view.blink_on;

    always_comb begin
        if (view.set_mode) begin
            val[0] = {1'b0, view.set_hh};
            val[1] = view.set_mm;
            val[2] = view.set_ss;
        end else begin
            val[0] = {1'b0, view.hh};
            val[1] = view.mm;
            val[2] = view.ss;
        end
        blank[0] = dark && (view.field == dcsm_pkg::FIELD_HOURS);
        blank[1] = dark && (view.field == dcsm_pkg::FIELD_MINUTES);
        blank[2] = dark && (view.field == dcsm_pkg::FIELD_SECONDS);
        for (int i = 0; i < 3; i++) begin
            tens[i] = dcsm_pkg::tens_of(val[i]);
            ones[i] = 4'(val[i] - 6'(tens[i]) * 6'd10);
            if (blank[i]) begin
                tens[i] = dcsm_pkg::BLANK;
                ones[i] = dcsm_pkg::BLANK;
            end
        end
    end

    assign digits = {ones[2], tens[2], ones[1], tens[1], ones[0], tens[0]};

endmodule
`default_nettype wire

// ===== rtl/core/digital_clock_with_set_mode.sv =====
// channel   dir  handshake            payload
// s_        in   s_tvalid/s_tready    tuser: cmd; tdata: key_code
// m_        out  m_tvalid/m_tready    tuser: in_set_mode, selected_field; tdata: six digits
// cfg_      in   cfg_valid/cfg_ready  cfg_index, cfg_data (16 bits)
//
// One item per cycle while m_tready keeps the result flowing; the input register takes the item
// at the transfer, and the state update and digit split then go into the result register once
// that register is empty or its result is taken.
// aresetn is synchronous: time 23:59:55, 1000 ticks/s, blink 500 ticks.
// A stalled result holds; one more item is taken into the input register meanwhile.
// cfg_ready is always high.
`default_nettype none
module digital_clock_with_set_mode (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [3:0] key_code, [7:4] zero
    input  wire logic [0:0]  s_tuser,   // [0] cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // from bit 0 up: hour tens, hour ones, minute tens,
                                        // minute ones, second tens, second ones, 4 bits each
    output logic [2:0]       m_tuser,   // [0] in_set_mode, [2:1] selected_field
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic            in_vld_reg, out_vld_reg;
    logic            in_cmd_reg;
    logic [3:0]      in_key_reg;
    logic            adv, fire;
    logic [23:0]     digits, digits_reg;
    logic [2:0]      user_reg;
    dcsm_pkg::view_t view;

    assign adv       = !out_vld_reg || m_tready;
    assign fire      = in_vld_reg && adv;
    assign s_tready  = !in_vld_reg || adv;
    assign cfg_ready = 1'b1;

    dcsm_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid),
        .cfg_idx   (cfg_index),
        .cfg_wdata (cfg_data),
        .fire      (fire),
        .cmd       (in_cmd_reg),
        .key       (in_key_reg),
        .view      (view)
    );

    dcsm_display u_disp (
        .view   (view),
        .digits (digits)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_tready) in_vld_reg <= s_tvalid;
            if (adv)      out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_cmd_reg <= s_tuser[0];
            in_key_reg <= s_tdata[3:0];
        end
        if (fire) begin
            digits_reg <= digits;
            user_reg   <= {view.field, view.set_mode};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = digits_reg;
    assign m_tuser  = user_reg;

endmodule
`default_nettype wire

// ===== rtl/core/dcsm_checker.sv =====
`default_nettype none
module dcsm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic [0:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [2:0]  m_tuser,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic        cfg_index,
    input wire logic [15:0] cfg_data
);

    logic unused;
    assign unused = ^{s_tdata, s_tuser, cfg_valid, cfg_ready, cfg_index, cfg_data};

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // outside set mode nothing is blanked
    a_no_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |->
            m_tdata[3:0] != dcsm_pkg::BLANK && m_tdata[7:4] != dcsm_pkg::BLANK &&
            m_tdata[11:8] != dcsm_pkg::BLANK && m_tdata[15:12] != dcsm_pkg::BLANK &&
            m_tdata[19:16] != dcsm_pkg::BLANK && m_tdata[23:20] != dcsm_pkg::BLANK)
        else $error("blank digit outside set mode");

    a_field_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[2:1] != 2'd3)
        else $error("selected field out of range");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> ##1 m_tvalid)
        else $error("result missing two cycles after transfer");

endmodule

bind digital_clock_with_set_mode dcsm_checker u_chk (.*);
`default_nettype wire
